FILE: hw/rtl/tmbc_pkg.sv
// ----------------------------------------------------------------------------
// tmbc_pkg
// shared types, constants and codes of the tile map box collision resolver
// ----------------------------------------------------------------------------
package tmbc_pkg;

	localparam int DEF_MAX_COLUMNS   = 64;
	localparam int DEF_MAX_ROWS      = 64;
	localparam int DEF_FRACTION_BITS = 4;

	localparam int POS_W  = 20;
	localparam int WORK_W = 26;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	localparam logic [7:0] CODE_FLOOR  = 8'h2E;
	localparam logic [7:0] CODE_LADDER = 8'h6C;
	localparam logic [7:0] CODE_SAND   = 8'h73;

	localparam logic [2:0] REG_MAP_COLUMNS = 3'd0;
	localparam logic [2:0] REG_MAP_ROWS    = 3'd1;
	localparam logic [2:0] REG_TILE_SHIFT  = 3'd2;
	localparam logic [2:0] REG_BOX_WIDTH   = 3'd3;
	localparam logic [2:0] REG_BOX_HEIGHT  = 3'd4;
	localparam logic [2:0] REG_TILE_HALF   = 3'd5;

	localparam logic [6:0]  RST_MAP_COLUMNS = 7'd64;
	localparam logic [6:0]  RST_MAP_ROWS    = 7'd64;
	localparam logic [2:0]  RST_TILE_SHIFT  = 3'd5;
	localparam logic [11:0] RST_BOX_WIDTH   = 12'd512;
	localparam logic [11:0] RST_BOX_HEIGHT  = 12'd512;
	localparam logic [11:0] RST_TILE_HALF   = 12'd256;

	localparam logic [2:0] NUM_CORNERS = 3'd4;

	typedef struct packed {
		logic [6:0]  map_columns;
		logic [6:0]  map_rows;
		logic [2:0]  tile_shift;
		logic [11:0] box_width;
		logic [11:0] box_height;
		logic [11:0] tile_half;
	} cfg_t;

	typedef struct packed {
		logic       accept;
		logic       clear_en;
		logic       probe_issue;
		logic       probe_check;
		logic [1:0] probe_sel;
		logic       push_diff;
		logic       push_depth;
		logic       push_apply;
		logic [1:0] push_sel;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic       clear_last;
		logic [2:0] hit_n;
		logic       out_free;
	} sts_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_DIFF,
		ST_DEPTH,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/tmbc_regs.sv
// ----------------------------------------------------------------------------
// tmbc_regs
// apb configuration registers: map size, tile shift, box size, tile half extent
// ----------------------------------------------------------------------------
module tmbc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tmbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tmbc_pkg::DATA_W-1:0]  pwdata,
	output logic [tmbc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output tmbc_pkg::cfg_t               cfg
);
	import tmbc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_columns <= RST_MAP_COLUMNS;
			cfg_q.map_rows    <= RST_MAP_ROWS;
			cfg_q.tile_shift  <= RST_TILE_SHIFT;
			cfg_q.box_width   <= RST_BOX_WIDTH;
			cfg_q.box_height  <= RST_BOX_HEIGHT;
			cfg_q.tile_half   <= RST_TILE_HALF;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAP_COLUMNS: cfg_q.map_columns <= pwdata[6:0];
				REG_MAP_ROWS:    cfg_q.map_rows    <= pwdata[6:0];
				REG_TILE_SHIFT:  cfg_q.tile_shift  <= pwdata[2:0];
				REG_BOX_WIDTH:   cfg_q.box_width   <= pwdata[11:0];
				REG_BOX_HEIGHT:  cfg_q.box_height  <= pwdata[11:0];
				REG_TILE_HALF:   cfg_q.tile_half   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAP_COLUMNS: prdata = DATA_W'(cfg_q.map_columns);
			REG_MAP_ROWS:    prdata = DATA_W'(cfg_q.map_rows);
			REG_TILE_SHIFT:  prdata = DATA_W'(cfg_q.tile_shift);
			REG_BOX_WIDTH:   prdata = DATA_W'(cfg_q.box_width);
			REG_BOX_HEIGHT:  prdata = DATA_W'(cfg_q.box_height);
			REG_TILE_HALF:   prdata = DATA_W'(cfg_q.tile_half);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/tmbc_ctrl.sv
// ----------------------------------------------------------------------------
// tmbc_ctrl
// sequencer: clearing pass, corner probes, per-hit push steps, result hand-off
// ----------------------------------------------------------------------------
module tmbc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           op,
	output logic           in_ready,
	input  tmbc_pkg::sts_t sts,
	output tmbc_pkg::cmd_t cmd
);
	import tmbc_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) state_d = (op == OP_RESOLVE) ? ST_PROBE : ST_DONE;
			end
			ST_PROBE: if (cnt_q == NUM_CORNERS) state_d = ST_DIFF;
			ST_DIFF: state_d = (cnt_q == sts.hit_n) ? ST_DONE : ST_DEPTH;
			ST_DEPTH: state_d = ST_APPLY;
			ST_APPLY: state_d = ST_DIFF;
			ST_DONE: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE:  cmd.accept = in_valid;
			ST_PROBE: begin
				cmd.probe_issue = (cnt_q != NUM_CORNERS);
				cmd.probe_check = (cnt_q != 3'd0);
				cmd.probe_sel   = cnt_q[1:0];
			end
			ST_DIFF: begin
				cmd.push_diff = (cnt_q != sts.hit_n);
				cmd.push_sel  = cnt_q[1:0];
			end
			ST_DEPTH: cmd.push_depth = 1'b1;
			ST_APPLY: cmd.push_apply = 1'b1;
			ST_DONE:  cmd.finish = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_PROBE) begin
				cnt_q <= (cnt_q == NUM_CORNERS) ? 3'd0 : cnt_q + 3'd1;
			end else if (state_q == ST_APPLY) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free) else $error("result loaded while output full");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready) else $error("accept during clearing pass");
	a_apply_after_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> ($past(state_q) == ST_DEPTH))
		else $error("push applied without depth step");
	a_push_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF) |-> (cnt_q <= sts.hit_n)) else $error("push index past hits");

endmodule

FILE: hw/rtl/tmbc_dpath.sv
// ----------------------------------------------------------------------------
// tmbc_dpath
// tile memory, corner probe, hit list, push arithmetic and output register
// ----------------------------------------------------------------------------
module tmbc_dpath #(
	parameter int MAX_COLUMNS   = tmbc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS      = tmbc_pkg::DEF_MAX_ROWS,
	parameter int FRACTION_BITS = tmbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tmbc_pkg::cfg_t                     cfg,
	input  tmbc_pkg::cmd_t                     cmd,
	output tmbc_pkg::sts_t                     sts,
	input  logic [5:0]                         tile_col,
	input  logic [5:0]                         tile_row,
	input  logic [7:0]                         tile_code,
	input  logic signed [tmbc_pkg::POS_W-1:0]  box_x,
	input  logic signed [tmbc_pkg::POS_W-1:0]  box_y,
	input  logic [7:0]                         speed,
	input  logic                               op,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tmbc_pkg::POS_W-1:0]  new_x,
	output logic signed [tmbc_pkg::POS_W-1:0]  new_y,
	output logic                               collided,
	output logic [2:0]                         hit_count
);
	import tmbc_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int GXW   = $clog2(MAX_COLUMNS);
	localparam int GYW   = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int SW    = $clog2(8 + FRACTION_BITS);
	localparam int WW    = WORK_W;
	localparam logic signed [WW-1:0] POS_MAX = WW'((1 << (POS_W - 1)) - 1);
	localparam logic signed [WW-1:0] POS_MIN = -WW'(1 << (POS_W - 1));

	// tile memory and clearing pass
	logic          tile_solid_q [DEPTH];
	logic [AW-1:0] clr_q;
	logic          mem_we, mem_wdata;
	logic [AW-1:0] mem_waddr;
	logic          wr_in_range;
	logic [AW-1:0] wr_addr;

	// working state
	logic signed [WW-1:0] x_q, y_q;
	logic [7:0]           speed_q;
	logic [2:0]           hit_n_q;
	logic [GXW-1:0]       hit_gx_q [4];
	logic [GYW-1:0]       hit_gy_q [4];

	// probe
	logic [SW-1:0]        s;
	logic [CW-1:0]        cols;
	logic [RW-1:0]        rows;
	logic signed [WW-1:0] px, py;
	logic [WW-1:0]        cx, cy;
	logic                 prb_inb;
	logic [AW-1:0]        prb_addr;
	logic                 rd_s1, inb_s1;
	logic [GXW-1:0]       gx_s1;
	logic [GYW-1:0]       gy_s1;

	// push
	logic signed [WW-1:0] w_ext, h_ext, r2_ext, tw;
	logic signed [WW-1:0] ox, oy, dx, dy;
	logic signed [WW-1:0] dx_q, dy_q, ddx_q, ddy_q;
	logic signed [WW-1:0] adx, ady, ddx, ddy, mx, my;

	// output register
	logic                 out_valid_q;
	logic signed [POS_W-1:0] new_x_q, new_y_q;
	logic [2:0]           hit_count_q;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] c;
		begin
			c = v;
			if (v > POS_MAX) c = POS_MAX;
			if (v < POS_MIN) c = POS_MIN;
			sat_pos = c[POS_W-1:0];
		end
	endfunction

	assign wr_in_range = (32'(tile_col) < MAX_COLUMNS) && (32'(tile_row) < MAX_ROWS);
	assign wr_addr     = AW'(AW'(tile_row) * AW'(MAX_COLUMNS)) + AW'(tile_col);

	always_comb begin
		if (cmd.clear_en) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = cmd.accept && (op == OP_WRITE) && wr_in_range;
			mem_waddr = wr_addr;
			mem_wdata = (tile_code != CODE_FLOOR) && (tile_code != CODE_LADDER) &&
			            (tile_code != CODE_SAND);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) tile_solid_q[mem_waddr] <= mem_wdata;
		if (cmd.probe_issue) rd_s1 <= tile_solid_q[prb_addr];
	end

	// corner probe
	assign s = SW'(cfg.tile_shift) + SW'(FRACTION_BITS);

	always_comb begin
		if (32'(cfg.map_columns) > MAX_COLUMNS) cols = CW'(MAX_COLUMNS);
		else cols = CW'(cfg.map_columns);
		if (32'(cfg.map_rows) > MAX_ROWS) rows = RW'(MAX_ROWS);
		else rows = RW'(cfg.map_rows);
	end

	always_comb begin
		unique case (cmd.probe_sel)
			2'd0: begin
				px = x_q + WW'(speed_q);
				py = y_q + WW'(speed_q);
			end
			2'd1: begin
				px = x_q + WW'(cfg.box_width);
				py = y_q;
			end
			2'd2: begin
				px = x_q;
				py = y_q + WW'(cfg.box_height);
			end
			default: begin
				px = x_q + WW'(cfg.box_width);
				py = y_q + WW'(cfg.box_height);
			end
		endcase
	end

	assign cx       = WW'(px) >> s;
	assign cy       = WW'(py) >> s;
	assign prb_inb  = !px[WW-1] && !py[WW-1] && (cx < WW'(cols)) && (cy < WW'(rows));
	assign prb_addr = AW'(AW'(cy[GYW-1:0]) * AW'(MAX_COLUMNS)) + AW'(cx[GXW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.probe_issue) begin
			inb_s1 <= prb_inb;
			gx_s1  <= cx[GXW-1:0];
			gy_s1  <= cy[GYW-1:0];
		end
	end

	// push arithmetic in doubled units
	assign w_ext  = WW'(cfg.box_width);
	assign h_ext  = WW'(cfg.box_height);
	assign r2_ext = WW'({cfg.tile_half, 1'b0});
	assign tw     = WW'(1) << s;
	assign ox     = WW'(hit_gx_q[cmd.push_sel]) << s;
	assign oy     = WW'(hit_gy_q[cmd.push_sel]) << s;
	assign dx     = ((x_q <<< 1) + w_ext) - ((ox <<< 1) + tw);
	assign dy     = ((y_q <<< 1) + h_ext) - ((oy <<< 1) + tw);
	assign adx    = dx_q[WW-1] ? -dx_q : dx_q;
	assign ady    = dy_q[WW-1] ? -dy_q : dy_q;
	assign ddx    = w_ext + r2_ext - adx;
	assign ddy    = h_ext + r2_ext - ady;
	assign mx     = (ddx_q + WW'(1)) >>> 1;
	assign my     = (ddy_q + WW'(1)) >>> 1;

	always_ff @(posedge clk) begin
		if (cmd.push_diff) begin
			dx_q <= dx;
			dy_q <= dy;
		end
		if (cmd.push_depth) begin
			ddx_q <= ddx;
			ddy_q <= ddy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= WW'(box_x);
			y_q     <= WW'(box_y);
			speed_q <= speed;
		end else if (cmd.push_apply && (ddx_q > 0) && (ddy_q > 0)) begin
			if (ddx_q < ddy_q) x_q <= dx_q[WW-1] ? x_q - mx : x_q + mx;
			else y_q <= dy_q[WW-1] ? y_q - my : y_q + my;
		end
		if (cmd.probe_check && inb_s1 && rd_s1) begin
			hit_gx_q[hit_n_q[1:0]] <= gx_s1;
			hit_gy_q[hit_n_q[1:0]] <= gy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_n_q <= '0;
		end else if (cmd.accept) begin
			hit_n_q <= '0;
		end else if (cmd.probe_check && inb_s1 && rd_s1) begin
			hit_n_q <= hit_n_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			new_x_q     <= sat_pos(x_q);
			new_y_q     <= sat_pos(y_q);
			hit_count_q <= hit_n_q;
		end
	end

	assign sts.clear_last = (clr_q == AW'(DEPTH - 1));
	assign sts.hit_n      = hit_n_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign new_x     = new_x_q;
	assign new_y     = new_y_q;
	assign hit_count = hit_count_q;
	assign collided  = (hit_count_q != 3'd0);

endmodule

FILE: hw/rtl/tile_map_box_collision_resolver_unit.sv
// ----------------------------------------------------------------------------
// tile_map_box_collision_resolver_unit
// solid tile map with box corner probing and axis push-out resolution
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     op tile_col tile_row tile_code box_x box_y speed
//  out      out_valid / out_ready   new_x new_y collided hit_count
//  cfg      apb psel/penable/pwrite paddr pwdata prdata (pready tied high)
//
//  a tile write transaction goes from idle straight to done; a resolve probes first
//  the four probes go one after another through the single tile memory read
//  port, and each hit takes a difference, depth and apply step
//  after reset a clearing pass zeroes all MAX_ROWS * MAX_COLUMNS tile memory
//  entries (4096 by default); in_ready stays low until it ends
//  a result waits in the output register, a new transaction is taken meanwhile
// ----------------------------------------------------------------------------
module tile_map_box_collision_resolver_unit #(
	parameter int MAX_COLUMNS   = tmbc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS      = tmbc_pkg::DEF_MAX_ROWS,
	parameter int FRACTION_BITS = tmbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               op,
	input  logic [5:0]                         tile_col,
	input  logic [5:0]                         tile_row,
	input  logic [7:0]                         tile_code,
	input  logic signed [tmbc_pkg::POS_W-1:0]  box_x,
	input  logic signed [tmbc_pkg::POS_W-1:0]  box_y,
	input  logic [7:0]                         speed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tmbc_pkg::POS_W-1:0]  new_x,
	output logic signed [tmbc_pkg::POS_W-1:0]  new_y,
	output logic                               collided,
	output logic [2:0]                         hit_count,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tmbc_pkg::ADDR_W-1:0]        paddr,
	input  logic [tmbc_pkg::DATA_W-1:0]        pwdata,
	output logic [tmbc_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import tmbc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tmbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tmbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmbc_dpath #(
		.MAX_COLUMNS   (MAX_COLUMNS),
		.MAX_ROWS      (MAX_ROWS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.tile_code (tile_code),
		.box_x     (box_x),
		.box_y     (box_y),
		.speed     (speed),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_x     (new_x),
		.new_y     (new_y),
		.collided  (collided),
		.hit_count (hit_count)
	);

endmodule
